@@ sv/rss_pkg.sv @@
// ----------------------------------------------------------------------------
// Record score sorter package
// Shared sizes, the stored entry layout, the memory request and the
// sequencer states of the record score insertion sorter.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int MAX_RECORDS = 32;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int TAG_W       = 8;
    localparam int GRADE_W     = 4;
    localparam int SUM_W       = 7;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [SUM_W-1:0] sum;
    } entry_t;

    typedef struct packed {
        logic   we;
        idx_t   waddr;
        entry_t wdata;
        logic   re;
        idx_t   raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_OUT
    } state_t;

endpackage

@@ sv/rss_channels.sv @@
// ----------------------------------------------------------------------------
// Record score sorter channels
// Valid and ready channels for the incoming records and the sorted results.
// ----------------------------------------------------------------------------
interface rss_rec_if import rss_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TAG_W-1:0]   record_tag;
    logic [GRADE_W-1:0] grade_a;
    logic [GRADE_W-1:0] grade_b;
    logic [GRADE_W-1:0] grade_c;
    logic [GRADE_W-1:0] grade_d;
    logic [GRADE_W-1:0] grade_e;
    logic [GRADE_W-1:0] grade_f;
    logic [GRADE_W-1:0] grade_g;
    logic [GRADE_W-1:0] grade_h;
    logic               last_record;

    modport source (
        output valid, record_tag, grade_a, grade_b, grade_c, grade_d,
               grade_e, grade_f, grade_g, grade_h, last_record,
        input  ready
    );
    modport sink (
        input  valid, record_tag, grade_a, grade_b, grade_c, grade_d,
               grade_e, grade_f, grade_g, grade_h, last_record,
        output ready
    );
endinterface

interface rss_res_if import rss_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [TAG_W-1:0] out_tag;
    logic [SUM_W-1:0] score_sum;
    logic             last_out;

    modport source (
        output valid, out_tag, score_sum, last_out,
        input  ready
    );
    modport sink (
        input  valid, out_tag, score_sum, last_out,
        output ready
    );
endinterface

@@ sv/rss_store.sv @@
// ----------------------------------------------------------------------------
// Record store
// Single write, single read memory of tag and score entries with a
// registered read port.
// ----------------------------------------------------------------------------
module rss_store import rss_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mem_req,
    output entry_t   mem_rdata
);

    entry_t mem [MAX_RECORDS];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rdata_reg <= mem[mem_req.raddr];
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

@@ sv/rss_ctrl.sv @@
// ----------------------------------------------------------------------------
// Record score sorter sequencer
// Inserts each record into the sorted store by shifting larger entries up
// one place a cycle through a single score comparator, then reads the store
// back from the top entry down.
// ----------------------------------------------------------------------------
module rss_ctrl import rss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    rss_rec_if.sink          rec_in,
    input  logic [SUM_W-1:0] score,
    rss_res_if.source        res_out,
    output mem_req_t         mem_req,
    input  entry_t           mem_rdata
);

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    idx_t   pos_reg, pos_next;
    entry_t new_reg, new_next;
    logic   last_reg, last_next;
    entry_t out_reg, out_next;
    logic   out_last_reg, out_last_next;
    logic   greater;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        new_reg      <= new_next;
        last_reg     <= last_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign greater = mem_rdata.sum > new_reg.sum;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        new_next      = new_reg;
        last_next     = last_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        mem_req       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (rec_in.valid)
                begin
                    new_next  = '{tag: rec_in.record_tag, sum: score};
                    last_next = rec_in.last_record;
                    if (count_reg < cnt_t'(MAX_RECORDS))
                    begin
                        pos_next   = count_reg[IDX_W-1:0];
                        count_next = count_reg + cnt_t'(1);
                        state_next = ST_READ;
                    end
                    else if (rec_in.last_record)
                    begin
                        pos_next   = idx_t'(count_reg - cnt_t'(1));
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_READ:
            begin
                if (pos_reg == '0)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = pos_reg - idx_t'(1);
                    state_next    = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                if (greater)
                begin
                    mem_req.wdata = mem_rdata;
                    pos_next      = pos_reg - idx_t'(1);
                    if (pos_reg == idx_t'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = pos_reg - idx_t'(2);
                    end
                end
                else
                begin
                    mem_req.wdata = new_reg;
                    pos_next      = idx_t'(count_reg - cnt_t'(1));
                    state_next    = last_reg ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = new_reg;
                pos_next      = idx_t'(count_reg - cnt_t'(1));
                state_next    = last_reg ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = pos_reg;
                state_next    = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                out_next      = mem_rdata;
                out_last_next = (pos_reg == '0);
                state_next    = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (res_out.ready)
                begin
                    if (pos_reg == '0)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg - idx_t'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rec_in.ready      = (state_reg == ST_IDLE);
    assign res_out.valid     = (state_reg == ST_EMIT_OUT);
    assign res_out.out_tag   = out_reg.tag;
    assign res_out.score_sum = out_reg.sum;
    assign res_out.last_out  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(MAX_RECORDS))
        else $error("Record count exceeds the store capacity.");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (cnt_t'(mem_req.waddr) < count_reg))
        else $error("Store written beyond the held records.");

    a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (pos_reg != '0))
        else $error("Shift step reached the bottom of the store.");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.ready && res_out.last_out)
        |=> (count_reg == '0) && rec_in.ready)
        else $error("Store not emptied after the final result.");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |-> (count_reg != '0))
        else $error("Result offered from an empty store.");

endmodule

@@ sv/record_score_insertion_sorter_unit.sv @@
// ----------------------------------------------------------------------------
// Record score insertion sorter
// Loading a record shifts each held entry of higher score up one place and
// writes the record into the place left free. A sorted run leaves from the
// highest score down, each result read once the one before is taken.
// The block is ready again in the cycle after the final result is taken.
// Reset empties the set at once; the store contents are left as they are.
// ----------------------------------------------------------------------------
module record_score_insertion_sorter_unit import rss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rss_rec_if.sink   rec_in,
    rss_res_if.source res_out
);

    logic [SUM_W-1:0] score;
    mem_req_t         mem_req;
    entry_t           mem_rdata;

    assign score = SUM_W'(rec_in.grade_a) + SUM_W'(rec_in.grade_b)
                 + SUM_W'(rec_in.grade_c) + SUM_W'(rec_in.grade_d)
                 + SUM_W'(rec_in.grade_e) + SUM_W'(rec_in.grade_f)
                 + SUM_W'(rec_in.grade_g) + SUM_W'(rec_in.grade_h);

    rss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_in    (rec_in),
        .score     (score),
        .res_out   (res_out),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    rss_store u_store (
        .clk       (clk),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

endmodule

@@ tb/sv/tb_record_score_insertion_sorter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record score insertion sorter testbench
// Sends sets of records and predicts each sorted run: every record's score
// is the sum of its eight grades, and a set is ranked by score in
// descending order, with later records first among equal scores. Each
// result is checked field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_record_score_insertion_sorter_unit;
    import rss_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int TARGET_ITEMS  = 400;
    localparam int GRADES        = 8;

    typedef struct {
        logic [TAG_W-1:0] tag;
        logic [SUM_W-1:0] sum;
        logic             is_last;
    } ranked_t;

    logic clk;
    logic rst_n;

    rss_rec_if rec_if ();
    rss_res_if res_if ();

    record_score_insertion_sorter_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rec_in  (rec_if),
        .res_out (res_if)
    );

    logic [TAG_W-1:0] held_tag[$];
    logic [SUM_W-1:0] held_sum[$];
    ranked_t          ranked_due[$];
    ranked_t          due_head;
    int               error_count = 0;
    int               cycle_count = 0;
    int               items_sent  = 0;
    bit               steady      = 1'b0;

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    function automatic int idle_length();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [GRADES*GRADE_W-1:0] random_grades();
        logic [GRADES*GRADE_W-1:0] grades;
        logic [GRADE_W-1:0]        level;
        int                        mode;
        mode  = $urandom_range(0, 9);
        level = GRADE_W'($urandom_range(0, 15));
        for (int i = 0; i < GRADES; i++)
        begin
            if (mode < 6)
                grades[i*GRADE_W +: GRADE_W] = GRADE_W'($urandom_range(0, 15));
            else if (mode < 9)
                grades[i*GRADE_W +: GRADE_W] = $urandom_range(0, 1) ? '1 : '0;
            else
                grades[i*GRADE_W +: GRADE_W] = level;
        end
        return grades;
    endfunction

    task automatic rank_held_set();
        logic [TAG_W-1:0] t;
        logic [SUM_W-1:0] s;
        int               pos;
        ranked_t          r;
        for (int i = 1; i < held_sum.size(); i++)
        begin
            t   = held_tag[i];
            s   = held_sum[i];
            pos = i;
            while (pos > 0 && held_sum[pos-1] > s)
            begin
                held_tag[pos] = held_tag[pos-1];
                held_sum[pos] = held_sum[pos-1];
                pos--;
            end
            held_tag[pos] = t;
            held_sum[pos] = s;
        end
        for (int k = held_sum.size() - 1; k >= 0; k--)
        begin
            r.tag     = held_tag[k];
            r.sum     = held_sum[k];
            r.is_last = (k == 0);
            ranked_due.push_back(r);
        end
        held_tag.delete();
        held_sum.delete();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rec_if.valid && rec_if.ready)
        begin
            if (held_sum.size() < MAX_RECORDS)
            begin
                held_tag.push_back(rec_if.record_tag);
                held_sum.push_back(SUM_W'(rec_if.grade_a) + SUM_W'(rec_if.grade_b)
                                 + SUM_W'(rec_if.grade_c) + SUM_W'(rec_if.grade_d)
                                 + SUM_W'(rec_if.grade_e) + SUM_W'(rec_if.grade_f)
                                 + SUM_W'(rec_if.grade_g) + SUM_W'(rec_if.grade_h));
            end
            if (rec_if.last_record)
                rank_held_set();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (ranked_due.size() == 0)
            begin
                $error("unexpected result: out_tag %0d score_sum %0d last_out %0b",
                       res_if.out_tag, res_if.score_sum, res_if.last_out);
                error_count++;
            end
            else
            begin
                due_head = ranked_due.pop_front();
                if (res_if.out_tag !== due_head.tag)
                begin
                    $error("out_tag: expected %0d, actual %0d", due_head.tag, res_if.out_tag);
                    error_count++;
                end
                if (res_if.score_sum !== due_head.sum)
                begin
                    $error("score_sum: expected %0d, actual %0d",
                           due_head.sum, res_if.score_sum);
                    error_count++;
                end
                if (res_if.last_out !== due_head.is_last)
                begin
                    $error("last_out: expected %0b, actual %0b",
                           due_head.is_last, res_if.last_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_record_score_insertion_sorter_unit failed");
            $finish;
        end
    end

    initial
    begin : sink_pacing
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                stall_left = idle_length();
            end
        end
    end

    task automatic send_record(input logic [TAG_W-1:0] tag,
                               input logic [GRADES*GRADE_W-1:0] grades,
                               input logic is_last);
        int gap;
        rec_if.valid       <= 1'b1;
        rec_if.record_tag  <= tag;
        rec_if.grade_a     <= grades[0*GRADE_W +: GRADE_W];
        rec_if.grade_b     <= grades[1*GRADE_W +: GRADE_W];
        rec_if.grade_c     <= grades[2*GRADE_W +: GRADE_W];
        rec_if.grade_d     <= grades[3*GRADE_W +: GRADE_W];
        rec_if.grade_e     <= grades[4*GRADE_W +: GRADE_W];
        rec_if.grade_f     <= grades[5*GRADE_W +: GRADE_W];
        rec_if.grade_g     <= grades[6*GRADE_W +: GRADE_W];
        rec_if.grade_h     <= grades[7*GRADE_W +: GRADE_W];
        rec_if.last_record <= is_last;
        @(posedge clk);
        while (!rec_if.ready)
            @(posedge clk);
        items_sent++;
        gap = idle_length();
        if (gap > 0)
        begin
            rec_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_set(input int size);
        for (int i = 0; i < size; i++)
            send_record(TAG_W'($urandom_range(0, 255)), random_grades(), i == size - 1);
    endtask

    task automatic wait_results_drained();
        rec_if.valid <= 1'b0;
        @(posedge clk);
        while (ranked_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_cases();
        logic [GRADES*GRADE_W-1:0] lane;
        send_record(8'h00, '0, 1'b1);
        send_record(8'hFF, '1, 1'b1);
        send_record(8'hAA, {GRADES{4'hA}}, 1'b0);
        send_record(8'h55, {GRADES{4'h5}}, 1'b1);
        send_record(8'h10, {GRADES{4'h3}}, 1'b0);
        send_record(8'h11, {GRADES{4'h1}}, 1'b0);
        send_record(8'h12, {GRADES{4'h3}}, 1'b0);
        send_record(8'h13, {GRADES{4'hF}}, 1'b0);
        send_record(8'h14, {{(GRADES-1){4'h0}}, 4'h1}, 1'b0);
        send_record(8'h15, {GRADES{4'h3}}, 1'b1);
        for (int i = 0; i < GRADES; i++)
        begin
            lane = '0;
            lane[i*GRADE_W +: GRADE_W] = GRADE_W'(i + 8);
            send_record(TAG_W'(32'h20 + i), lane, i == GRADES - 1);
        end
    endtask

    task automatic test_store_full();
        send_random_set(MAX_RECORDS);
        send_random_set(MAX_RECORDS + 4);
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 3; i++)
        begin
            send_random_set($urandom_range(1, 8));
            wait_results_drained();
        end
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        for (int i = 0; i < 4; i++)
            send_random_set($urandom_range(1, 16));
        steady = 1'b0;
    endtask

    task automatic test_random_sets();
        int roll;
        while (items_sent < TARGET_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                send_random_set($urandom_range(1, 8));
            else if (roll < 90)
                send_random_set($urandom_range(9, MAX_RECORDS - 1));
            else if (roll < 96)
                send_random_set(MAX_RECORDS);
            else
                send_random_set($urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 8));
            if ($urandom_range(0, 9) == 0)
                wait_results_drained();
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        rec_if.valid       <= 1'b0;
        rec_if.record_tag  <= '0;
        rec_if.grade_a     <= '0;
        rec_if.grade_b     <= '0;
        rec_if.grade_c     <= '0;
        rec_if.grade_d     <= '0;
        rec_if.grade_e     <= '0;
        rec_if.grade_f     <= '0;
        rec_if.grade_g     <= '0;
        rec_if.grade_h     <= '0;
        rec_if.last_record <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_store_full();
        test_drain_pause();
        test_back_to_back();
        test_random_sets();

        rec_if.valid <= 1'b0;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_record_score_insertion_sorter_unit passed");
        else
            $display("tb_record_score_insertion_sorter_unit failed");
        $finish;
    end

endmodule
